[rtl/ctrd_pkg.sv]
`default_nettype none
package ctrd_pkg;

	// Number of stored channels and the index width that follows from it.
	localparam int CHANNELS = 16;
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int LEVEL_W = 16;
	localparam int GATE_W = 17;
	localparam int TICK_W = 32;
	localparam int PROD_W = LEVEL_W + GATE_W;

	localparam logic [GATE_W-1:0] GATE_ONE = 17'd65536;

	// Item kinds.
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_GATE = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	// Event kinds.
	localparam logic EV_STUCK = 1'b0;
	localparam logic EV_MISS = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] REG_MISS_THR = 2'd0;
	localparam logic [1:0] REG_STUCK_THR = 2'd1;
	localparam logic [1:0] REG_REFR_LEN = 2'd2;

	localparam logic [LEVEL_W-1:0] MISS_THR_RST = 16'd19661;
	localparam logic [LEVEL_W-1:0] STUCK_THR_RST = 16'd36045;
	localparam logic [LEVEL_W-1:0] REFR_LEN_RST = 16'd30;

	// Access to the channel level store.
	typedef struct packed {
		logic               wr_en;
		logic [IDX_W-1:0]   wr_addr;
		logic [LEVEL_W-1:0] wr_data;
		logic               rd_en;
		logic [IDX_W-1:0]   rd_addr;
	} store_req_t;

endpackage
`default_nettype wire

[rtl/ctrd_store.sv]
`default_nettype none
module ctrd_store (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ctrd_pkg::store_req_t       req,
	output logic [ctrd_pkg::LEVEL_W-1:0]    rd_level
);
	import ctrd_pkg::*;

	logic [LEVEL_W-1:0] mem [CHANNELS];
	logic [LEVEL_W-1:0] rd_data_q;
	logic [CHANNELS-1:0] vld_q;
	logic rd_hit_q;

	// An entry that was never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_hit_q <= vld_q[req.rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_level = rd_hit_q ? rd_data_q : '0;

endmodule
`default_nettype wire

[rtl/ctrd_scale.sv]
`default_nettype none
module ctrd_scale (
	input  wire logic                        clk,
	input  wire logic                        load,
	input  wire logic [ctrd_pkg::LEVEL_W-1:0] max_level,
	input  wire logic [ctrd_pkg::GATE_W-1:0]  gate_level,
	input  wire logic                        gate_on,
	output logic [ctrd_pkg::LEVEL_W-1:0]     gated_level
);
	import ctrd_pkg::*;

	logic [GATE_W-1:0] gate_eff;
	logic [GATE_W-1:0] factor;
	logic [PROD_W-1:0] product_q;
	logic [PROD_W:0] rounded;

	// A gate above one counts as one.
	always_comb begin
		gate_eff = gate_on ? gate_level : '0;
		if (gate_eff > GATE_ONE) begin
			gate_eff = GATE_ONE;
		end
		factor = GATE_ONE - gate_eff;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			product_q <= PROD_W'(max_level) * PROD_W'(factor);
		end
	end

	// Round half up, then saturate.
	assign rounded = {1'b0, product_q} + (PROD_W + 1)'(32768);
	assign gated_level = (rounded[PROD_W:32] != '0) ? '1 : rounded[31:16];

endmodule
`default_nettype wire

[rtl/contact_threshold_refractory_detector_core.sv]
`default_nettype none
// Contact detector core. Items enter one at a time. A channel sample or a gate update
// is taken without leaving the idle state; kind 3 is dropped. A tick walks the states
// SCAN, DRAIN, DECIDE and EMIT: one read of the level memory per channel, one state for the
// last read to return, one to decide and start the gate multiply, and one to hand
// the events to the output register. A tick's events wait there, and the next tick
// holds before its events until the output side has taken every earlier word. The
// level memory starts at zero after reset with no clearing pass.
module contact_threshold_refractory_detector_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic [1:0]                    kind,
	input  wire logic [3:0]                    channel,
	input  wire logic [ctrd_pkg::LEVEL_W-1:0]  sample_level,
	input  wire logic [ctrd_pkg::GATE_W-1:0]   gate_level,
	input  wire logic                          gate_on,
	input  wire logic [ctrd_pkg::TICK_W-1:0]   tick_number,
	output logic                               event_valid,
	input  wire logic                          event_stall,
	output logic                               event_kind,
	output logic [ctrd_pkg::TICK_W-1:0]        event_tick,
	output logic [ctrd_pkg::LEVEL_W-1:0]       intensity,
	output logic                               last_of_run,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [ctrd_pkg::LEVEL_W-1:0]  cfg_data
);
	import ctrd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

	logic [2:0] state_q;
	logic [IDX_W-1:0] addr_q;
	logic rd_valid_s1;
	logic [LEVEL_W-1:0] max_q;
	logic [TICK_W-1:0] tick_q;
	logic stuck_q;
	logic miss_q;

	logic [LEVEL_W-1:0] miss_thr_q;
	logic [LEVEL_W-1:0] stuck_thr_q;
	logic [LEVEL_W-1:0] refr_len_q;
	logic [LEVEL_W-1:0] refr_left_q;
	logic [GATE_W-1:0] gate_level_q;
	logic gate_on_q;

	// Two-word output buffer: slot 0 drives the ports.
	logic out_valid_q;
	logic out_kind_q;
	logic [TICK_W-1:0] out_tick_q;
	logic [LEVEL_W-1:0] out_level_q;
	logic out_last_q;
	logic pend_valid_q;
	logic pend_kind_q;
	logic [LEVEL_W-1:0] pend_level_q;

	logic accept;
	logic out_take;
	logic [8:0] chan_wide;
	logic chan_ok;
	logic scale_load;
	logic [LEVEL_W-1:0] rd_level;
	logic [LEVEL_W-1:0] gated_level;
	store_req_t store_req;

	assign item_stall = (state_q != ST_IDLE);
	assign accept = item_valid && !item_stall;
	assign out_take = out_valid_q && !event_stall;
	assign cfg_ready = 1'b1;

	assign chan_wide = {5'd0, channel};
	assign chan_ok = chan_wide < 9'(CHANNELS);

	always_comb begin
		store_req.wr_en = accept && (kind == KIND_SAMPLE) && chan_ok;
		store_req.wr_addr = chan_wide[IDX_W-1:0];
		store_req.wr_data = sample_level;
		store_req.rd_en = (state_q == ST_SCAN);
		store_req.rd_addr = addr_q;
	end

	assign scale_load = (state_q == ST_DECIDE);

	ctrd_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (store_req),
		.rd_level (rd_level)
	);

	ctrd_scale u_scale (
		.clk         (clk),
		.load        (scale_load),
		.max_level   (max_q),
		.gate_level  (gate_level_q),
		.gate_on     (gate_on_q),
		.gated_level (gated_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_thr_q <= MISS_THR_RST;
			stuck_thr_q <= STUCK_THR_RST;
			refr_len_q <= REFR_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MISS_THR: miss_thr_q <= cfg_data;
				REG_STUCK_THR: stuck_thr_q <= cfg_data;
				REG_REFR_LEN: refr_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q <= '0;
			rd_valid_s1 <= 1'b0;
			max_q <= '0;
			stuck_q <= 1'b0;
			miss_q <= 1'b0;
			refr_left_q <= '0;
			gate_level_q <= '0;
			gate_on_q <= 1'b0;
		end else begin
			rd_valid_s1 <= store_req.rd_en;
			if (rd_valid_s1 && (rd_level > max_q)) begin
				max_q <= rd_level;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (kind)
							KIND_GATE: begin
								gate_level_q <= gate_level;
								gate_on_q <= gate_on;
							end
							KIND_TICK: begin
								addr_q <= '0;
								max_q <= '0;
								state_q <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (addr_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					stuck_q <= max_q > stuck_thr_q;
					miss_q <= 1'b0;
					if (refr_left_q != '0) begin
						refr_left_q <= refr_left_q - 1'b1;
					end else if (max_q > miss_thr_q) begin
						miss_q <= 1'b1;
						refr_left_q <= refr_len_q;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// The buffer is loaded in this state once it is empty.
					if (!(stuck_q || miss_q) || !out_valid_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (kind == KIND_TICK)) begin
			tick_q <= tick_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && (stuck_q || miss_q) && !out_valid_q) begin
			out_valid_q <= 1'b1;
			pend_valid_q <= stuck_q && miss_q;
		end else if (out_take) begin
			out_valid_q <= pend_valid_q;
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && (stuck_q || miss_q) && !out_valid_q) begin
			out_tick_q <= tick_q;
			out_kind_q <= stuck_q ? EV_STUCK : EV_MISS;
			out_level_q <= stuck_q ? max_q : gated_level;
			out_last_q <= !(stuck_q && miss_q);
			pend_kind_q <= EV_MISS;
			pend_level_q <= gated_level;
		end else if (out_take && pend_valid_q) begin
			out_kind_q <= pend_kind_q;
			out_level_q <= pend_level_q;
			out_last_q <= 1'b1;
		end
	end

	assign event_valid = out_valid_q;
	assign event_kind = out_kind_q;
	assign event_tick = out_tick_q;
	assign intensity = out_level_q;
	assign last_of_run = out_last_q;

endmodule
`default_nettype wire

[bench/ctrd_event_checker.sv]
`timescale 1ns / 100ps
module ctrd_event_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  logic                          item_stall,
	input  logic [1:0]                    kind,
	input  logic [3:0]                    channel,
	input  logic [ctrd_pkg::LEVEL_W-1:0]  sample_level,
	input  logic [ctrd_pkg::GATE_W-1:0]   gate_level,
	input  logic                          gate_on,
	input  logic [ctrd_pkg::TICK_W-1:0]   tick_number,
	input  logic                          event_valid,
	input  logic                          event_stall,
	input  logic                          event_kind,
	input  logic [ctrd_pkg::TICK_W-1:0]   event_tick,
	input  logic [ctrd_pkg::LEVEL_W-1:0]  intensity,
	input  logic                          last_of_run,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [ctrd_pkg::LEVEL_W-1:0]  cfg_data,
	output int                            mismatches,
	output int                            pending_events
);
	import ctrd_pkg::*;

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic               kind;
		logic [TICK_W-1:0]  tick;
		logic [LEVEL_W-1:0] level;
		logic               last;
	} event_word_t;

	event_word_t expected_events[$];

	logic [LEVEL_W-1:0] levels [CHANNELS];
	logic [LEVEL_W-1:0] miss_thr;
	logic [LEVEL_W-1:0] stuck_thr;
	logic [LEVEL_W-1:0] refr_len;
	logic [LEVEL_W-1:0] countdown;
	logic [GATE_W-1:0]  gate_held;
	logic               gate_active;

	always @(posedge clk or negedge arst_n) begin
		logic [LEVEL_W-1:0] peak;
		logic [GATE_W-1:0]  gate_eff;
		longint unsigned    scaled;
		logic               stuck_hit;
		logic               miss_hit;
		event_word_t        got;
		event_word_t        want;
		event_word_t        queued;
		if (!arst_n) begin
			foreach (levels[i])
				levels[i] = '0;
			miss_thr = MISS_THR_RST;
			stuck_thr = STUCK_THR_RST;
			refr_len = REFR_LEN_RST;
			countdown = '0;
			gate_held = '0;
			gate_active = 1'b0;
			expected_events.delete();
			mismatches = 0;
			pending_events <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MISS_THR: miss_thr = cfg_data;
					REG_STUCK_THR: stuck_thr = cfg_data;
					REG_REFR_LEN: refr_len = cfg_data;
					default: ;
				endcase
			end

			if (item_valid && !item_stall) begin
				case (kind)
					KIND_SAMPLE: levels[channel] = sample_level;
					KIND_GATE: begin
						gate_held = gate_level;
						gate_active = gate_on;
					end
					KIND_TICK: begin
						peak = '0;
						foreach (levels[i])
							if (levels[i] > peak)
								peak = levels[i];
						stuck_hit = peak > stuck_thr;
						miss_hit = 1'b0;
						scaled = 0;
						if (countdown != 0) begin
							countdown = countdown - 1'b1;
						end else if (peak > miss_thr) begin
							miss_hit = 1'b1;
							// A gate above one counts as one and scales the intensity down to zero.
							gate_eff = gate_active ? gate_held : '0;
							if (gate_eff > GATE_ONE)
								gate_eff = GATE_ONE;
							scaled = peak;
							scaled = (scaled * (GATE_ONE - gate_eff) + 64'd32768) >> 16;
							if (scaled > 64'hFFFF)
								scaled = 64'hFFFF;
							countdown = refr_len;
						end
						if (stuck_hit) begin
							queued = '{EV_STUCK, tick_number, peak, !miss_hit};
							expected_events = {expected_events, queued};
						end
						if (miss_hit) begin
							queued = '{EV_MISS, tick_number, scaled[15:0], 1'b1};
							expected_events = {expected_events, queued};
						end
					end
					default: ;
				endcase
			end

			if (event_valid && !event_stall) begin
				got = '{event_kind, event_tick, intensity, last_of_run};
				if (expected_events.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected event word: kind %0d tick %h intensity %0d last %0d",
							got.kind, got.tick, got.level, got.last);
				end else begin
					want = expected_events.pop_front();
					if (got.kind !== want.kind || got.tick !== want.tick
							|| got.level !== want.level || got.last !== want.last) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("event word mismatch: expected kind %0d tick %h ",
								want.kind, want.tick,
								"intensity %0d last %0d, ", want.level, want.last,
								"got kind %0d tick %h intensity %0d last %0d",
								got.kind, got.tick, got.level, got.last);
					end
				end
			end

			pending_events <= expected_events.size();
		end
	end

endmodule

[bench/contact_threshold_refractory_detector_core_tb.sv]
`timescale 1ns / 100ps
module contact_threshold_refractory_detector_core_tb;
	import ctrd_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 100;
	localparam int SETTLE_CYCLES = 48;
	localparam int CYCLE_LIMIT = 400000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [1:0]         kind = '0;
	logic [3:0]         channel = '0;
	logic [LEVEL_W-1:0] sample_level = '0;
	logic [GATE_W-1:0]  gate_level = '0;
	logic               gate_on = 1'b0;
	logic [TICK_W-1:0]  tick_number = '0;
	logic               event_valid;
	logic               event_stall = 1'b0;
	logic               event_kind;
	logic [TICK_W-1:0]  event_tick;
	logic [LEVEL_W-1:0] intensity;
	logic               last_of_run;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [LEVEL_W-1:0] cfg_data = '0;

	logic               quiet = 1'b0;
	logic [LEVEL_W-1:0] miss_now = MISS_THR_RST;
	logic [LEVEL_W-1:0] stuck_now = STUCK_THR_RST;
	logic [LEVEL_W-1:0] refr_now = REFR_LEN_RST;
	int                 cycles = 0;
	int                 mismatches;
	int                 pending_events;

	contact_threshold_refractory_detector_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.kind         (kind),
		.channel      (channel),
		.sample_level (sample_level),
		.gate_level   (gate_level),
		.gate_on      (gate_on),
		.tick_number  (tick_number),
		.event_valid  (event_valid),
		.event_stall  (event_stall),
		.event_kind   (event_kind),
		.event_tick   (event_tick),
		.intensity    (intensity),
		.last_of_run  (last_of_run),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	ctrd_event_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.kind           (kind),
		.channel        (channel),
		.sample_level   (sample_level),
		.gate_level     (gate_level),
		.gate_on        (gate_on),
		.tick_number    (tick_number),
		.event_valid    (event_valid),
		.event_stall    (event_stall),
		.event_kind     (event_kind),
		.event_tick     (event_tick),
		.intensity      (intensity),
		.last_of_run    (last_of_run),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.pending_events (pending_events)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		event_stall <= !quiet && ($urandom_range(0, 99) < 20);
	end

	// Filler values for the fields that an item of a given kind ignores.
	function automatic logic [3:0] any_chan();
		return 4'($urandom);
	endfunction

	function automatic logic [LEVEL_W-1:0] any_level();
		return LEVEL_W'($urandom);
	endfunction

	function automatic logic [GATE_W-1:0] any_gate();
		return GATE_W'($urandom);
	endfunction

	function automatic logic any_bit();
		return 1'($urandom);
	endfunction

	// Levels cluster at the extremes and right around the current thresholds.
	function automatic logic [LEVEL_W-1:0] pick_level();
		logic [LEVEL_W-1:0] wobble;
		wobble = LEVEL_W'($urandom_range(0, 4)) - 16'd2;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return miss_now + wobble;
			4, 5: return stuck_now + wobble;
			default: return LEVEL_W'($urandom);
		endcase
	endfunction

	task automatic push_item(input logic [1:0] k, input logic [3:0] ch,
			input logic [LEVEL_W-1:0] lvl, input logic [GATE_W-1:0] gl,
			input logic g_on, input logic [TICK_W-1:0] tn);
		while (!quiet && $urandom_range(0, 99) < 20) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		kind <= k;
		channel <= ch;
		sample_level <= lvl;
		gate_level <= gl;
		gate_on <= g_on;
		tick_number <= tn;
		do
			@(posedge clk);
		while (item_stall);
	endtask

	// Leaves cfg_valid high so that back-to-back writes follow each other without a gap.
	task automatic write_reg(input logic [1:0] idx, input logic [LEVEL_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	// A tick that yields no event can still be in flight once the queue is empty.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_events != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int made;
		int burst;
		logic [GATE_W-1:0] gate_pick;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, run at the reset register values.
		push_item(KIND_TICK, any_chan(), any_level(), any_gate(), any_bit(), 32'h0);
		push_item(KIND_UNUSED, any_chan(), any_level(), any_gate(), any_bit(), $urandom);
		push_item(KIND_GATE, any_chan(), any_level(), 17'h0, 1'b0, $urandom);
		push_item(KIND_SAMPLE, 4'd7, MISS_THR_RST, any_gate(), any_bit(), $urandom);
		push_item(KIND_TICK, any_chan(), any_level(), any_gate(), any_bit(), 32'h1);
		push_item(KIND_SAMPLE, 4'd7, MISS_THR_RST + 16'd1, any_gate(), any_bit(), $urandom);
		push_item(KIND_GATE, any_chan(), any_level(), 17'h1FFFF, 1'b1, $urandom);
		push_item(KIND_TICK, any_chan(), any_level(), any_gate(), any_bit(), 32'h2);
		push_item(KIND_SAMPLE, 4'd0, 16'hFFFF, any_gate(), any_bit(), $urandom);
		push_item(KIND_TICK, any_chan(), any_level(), any_gate(), any_bit(), 32'hFFFF_FFFF);
		push_item(KIND_SAMPLE, 4'd0, 16'h0, any_gate(), any_bit(), $urandom);
		push_item(KIND_SAMPLE, 4'd7, 16'h0, any_gate(), any_bit(), $urandom);
		push_item(KIND_SAMPLE, 4'd15, STUCK_THR_RST, any_gate(), any_bit(), $urandom);
		push_item(KIND_TICK, any_chan(), any_level(), any_gate(), any_bit(), $urandom);
		push_item(KIND_GATE, any_chan(), any_level(), GATE_ONE, 1'b1, $urandom);
		push_item(KIND_SAMPLE, 4'd15, STUCK_THR_RST + 16'd1, any_gate(), any_bit(), $urandom);
		push_item(KIND_TICK, any_chan(), any_level(), any_gate(), any_bit(), $urandom);
		push_item(KIND_GATE, any_chan(), any_level(), 17'd32768, 1'b1, $urandom);
		push_item(KIND_TICK, any_chan(), any_level(), any_gate(), any_bit(), $urandom);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase)
				0: refr_now = '0;
				1: begin
					miss_now = '0;
					stuck_now = '0;
					refr_now = '0;
				end
				2: begin
					miss_now = '1;
					stuck_now = '1;
					refr_now = '1;
				end
				3: begin
					miss_now = '1;
					stuck_now = '0;
					refr_now = 16'd1;
				end
				4: begin
					miss_now = '0;
					stuck_now = '1;
					refr_now = 16'd3;
				end
				default: begin
					miss_now = pick_level();
					stuck_now = pick_level();
					refr_now = ($urandom_range(0, 7) == 0) ? LEVEL_W'($urandom_range(0, 40))
						: LEVEL_W'($urandom_range(0, 5));
				end
			endcase
			write_reg(REG_MISS_THR, miss_now);
			write_reg(REG_STUCK_THR, stuck_now);
			write_reg(REG_UNUSED, any_level());
			write_reg(REG_REFR_LEN, refr_now);
			cfg_valid <= 1'b0;
			quiet <= (phase == 3);

			made = 0;
			while (made < PHASE_ITEMS) begin
				if ($urandom_range(0, 3) == 0) begin
					// Pull every channel down so that the peak can fall below the thresholds.
					for (int ch = 0; ch < CHANNELS; ch++)
						push_item(KIND_SAMPLE, 4'(ch), LEVEL_W'($urandom_range(0, miss_now)),
							any_gate(), any_bit(), $urandom);
					made += CHANNELS;
				end
				burst = $urandom_range(0, 4);
				repeat (burst)
					push_item(KIND_SAMPLE, any_chan(), pick_level(), any_gate(), any_bit(),
						$urandom);
				made += burst;
				if ($urandom_range(0, 3) == 0) begin
					case ($urandom_range(0, 5))
						0: gate_pick = '0;
						1: gate_pick = GATE_ONE;
						2: gate_pick = GATE_W'($urandom);
						default: gate_pick = GATE_W'($urandom_range(0, 65536));
					endcase
					push_item(KIND_GATE, any_chan(), any_level(), gate_pick, any_bit(), $urandom);
					made++;
				end
				if ($urandom_range(0, 15) == 0)
					push_item(KIND_UNUSED, any_chan(), any_level(), any_gate(), any_bit(),
						$urandom);
				burst = $urandom_range(1, 3);
				repeat (burst)
					push_item(KIND_TICK, any_chan(), any_level(), any_gate(), any_bit(),
						$urandom);
				made += burst;
				if ($urandom_range(0, 49) == 0)
					drain();
			end
		end

		drain();
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
